FILE: design/lkvt_pkg.sv
package lkvt_pkg;

  // Table size and the widths that follow from it.
  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths of the beats.
  localparam int CMD_W  = 2;
  localparam int KEY_W  = 64;
  localparam int VAL_W  = 64;
  localparam int USED_W = 5;

  // Command codes; the fourth code is a no-op that still reports found.
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } lkvt_item_t;

  typedef struct packed {
    logic              found;
    logic [VAL_W-1:0]  read_value;
    logic              value_nonzero;
    logic              table_full_drop;
    logic [USED_W-1:0] entries_used;
  } lkvt_result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the item and start at entry zero
    logic scan;       // compare the entry read last cycle
    logic rd_last;    // read the last entry
    logic rd_pos;     // read the value at the hit position
    logic wr_update;  // overwrite the value at the hit position
    logic wr_append;  // write a new entry at the end
    logic wr_move;    // copy the last entry into the hit position
    logic count_inc;
    logic count_dec;
    logic fetch;      // the value read last cycle is the lookup result
    logic drop;       // new key dropped, table full
    logic respond;    // register the result beat
  } lkvt_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic             count_zero;
    logic             full;
    logic             match;
    logic             scan_last;
    logic             hit;
    logic [CMD_W-1:0] command;
  } lkvt_stat_t;

endpackage

FILE: design/lkvt_ram.sv
module lkvt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/lkvt_ctrl.sv
module lkvt_ctrl import lkvt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  lkvt_stat_t stat,
  output lkvt_ctl_t  ctl,
  output logic       busy
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_ACT   = 5'b00100,
    S_MOVE  = 5'b01000,
    S_FETCH = 5'b10000
  } state_t;

  state_t state, state_next;

  assign busy = (state != S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          state_next = stat.count_zero ? S_ACT : S_SCAN;
        end
      end
      S_SCAN: begin
        ctl.scan = 1'b1;
        if (stat.match || stat.scan_last) begin
          state_next = S_ACT;
        end
      end
      S_ACT: begin
        state_next = S_IDLE;
        case (stat.command)
          CMD_INSERT: begin
            ctl.respond = 1'b1;
            if (stat.hit) begin
              ctl.wr_update = 1'b1;
            end else if (!stat.full) begin
              ctl.wr_append = 1'b1;
              ctl.count_inc = 1'b1;
            end else begin
              ctl.drop = 1'b1;
            end
          end
          CMD_REMOVE: begin
            if (stat.hit) begin
              ctl.rd_last = 1'b1;
              state_next  = S_MOVE;
            end else begin
              ctl.respond = 1'b1;
            end
          end
          CMD_LOOKUP: begin
            if (stat.hit) begin
              ctl.rd_pos = 1'b1;
              state_next = S_FETCH;
            end else begin
              ctl.respond = 1'b1;
            end
          end
          default: begin
            ctl.respond = 1'b1;
          end
        endcase
      end
      S_MOVE: begin
        ctl.wr_move   = 1'b1;
        ctl.count_dec = 1'b1;
        ctl.respond   = 1'b1;
        state_next    = S_IDLE;
      end
      S_FETCH: begin
        ctl.fetch   = 1'b1;
        ctl.respond = 1'b1;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: design/lkvt_dp.sv
module lkvt_dp import lkvt_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  lkvt_item_t   item,
  input  lkvt_ctl_t    ctl,
  output lkvt_stat_t   stat,
  output lkvt_result_t result,
  output logic         done
);

  logic [CMD_W-1:0] cmd_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q;
  logic [IDX_W-1:0] ptr;
  logic [IDX_W-1:0] pos;
  logic             hit_q;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] count_m1;
  logic [IDX_W-1:0] rd_addr;
  logic             key_we;
  logic [IDX_W-1:0] key_waddr;
  logic [KEY_W-1:0] key_wdata;
  logic             val_we;
  logic [IDX_W-1:0] val_waddr;
  logic [VAL_W-1:0] val_wdata;
  logic [KEY_W-1:0] key_rd;
  logic [VAL_W-1:0] val_rd;

  assign count_m1 = count - CNT_W'(1);

  // Status toward the controller.
  assign stat.count_zero = (count == '0);
  assign stat.full       = (count == CNT_W'(CAPACITY));
  assign stat.match      = (key_rd == key_q);
  assign stat.scan_last  = ((CNT_W'(ptr) + CNT_W'(1)) == count);
  assign stat.hit        = hit_q;
  assign stat.command    = cmd_q;

  // Shared read address of both stores.
  always_comb begin
    rd_addr = '0;
    if (ctl.scan) begin
      rd_addr = ptr + IDX_W'(1);
    end else if (ctl.rd_last) begin
      rd_addr = count_m1[IDX_W-1:0];
    end else if (ctl.rd_pos) begin
      rd_addr = pos;
    end
  end

  // Write ports: append at the end, overwrite in place, or move the last entry.
  always_comb begin
    key_we    = ctl.wr_append || ctl.wr_move;
    key_waddr = ctl.wr_move ? pos : count[IDX_W-1:0];
    key_wdata = ctl.wr_move ? key_rd : key_q;
    val_we    = ctl.wr_append || ctl.wr_move || ctl.wr_update;
    val_waddr = ctl.wr_append ? count[IDX_W-1:0] : pos;
    val_wdata = ctl.wr_move ? val_rd : val_q;
  end

  always_comb begin
    count_next = count;
    if (ctl.count_inc) begin
      count_next = count + CNT_W'(1);
    end else if (ctl.count_dec) begin
      count_next = count_m1;
    end
  end

  lkvt_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (rd_addr),
    .rdata (key_rd)
  );

  lkvt_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (rd_addr),
    .rdata (val_rd)
  );

  // Item capture and scan position.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q <= item.command;
      key_q <= item.key;
      val_q <= item.value;
      ptr   <= '0;
      hit_q <= 1'b0;
    end else if (ctl.scan) begin
      if (stat.match) begin
        hit_q <= 1'b1;
        pos   <= ptr;
      end else begin
        ptr <= ptr + IDX_W'(1);
      end
    end
  end

  // Entry count and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= ctl.respond;
    end
  end

  // Result beat register.
  always_ff @(posedge clk) begin
    if (ctl.respond) begin
      result.found           <= hit_q;
      result.read_value      <= ctl.fetch ? val_rd : '0;
      result.value_nonzero   <= ctl.fetch && (val_rd != '0);
      result.table_full_drop <= ctl.drop;
      result.entries_used    <= USED_W'(count_next);
    end
  end

endmodule

FILE: design/linear_key_value_table.sv
// Flow of an item: the scan compares one stored key at a time until a match or the last entry,
// then the command acts and its result is registered; a remove or lookup hit first reads the last
// entry or the hit value. Items are taken one at a time, with one compare a cycle through
// the key store's single read port. A new item is accepted in the cycle its predecessor's result shows.
// Reset (synchronous, active high) empties the table; stored entries are not cleared.
// The result beat is shown for exactly one cycle and cannot be stalled.
module linear_key_value_table import lkvt_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  lkvt_item_t   item,
  output lkvt_result_t result,
  output logic         done
);

  lkvt_ctl_t  ctl;
  lkvt_stat_t stat;

  lkvt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy)
  );

  lkvt_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .ctl    (ctl),
    .stat   (stat),
    .result (result),
    .done   (done)
  );

  // An accepted beat makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted beat did not make the block busy");

  // A result beat only follows a cycle of work.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result beat without work in progress");

  // The count never grows past the capacity.
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    !(stat.full && ctl.count_inc))
    else $error("append into a full table");

  // A move only happens on a table that holds entries.
  a_move_nonempty: assert property (@(posedge clk) disable iff (rst)
    ctl.wr_move |-> (!stat.count_zero && stat.hit))
    else $error("entry move without a hit in a nonempty table");

endmodule

FILE: tb/tb_linear_key_value_table.sv
`timescale 1ns / 100ps

module tb_linear_key_value_table;
  import lkvt_pkg::*;

  // The fourth command code does nothing but report whether the key is present.
  localparam logic [CMD_W-1:0] CMD_NOOP = 2'd3;
  localparam int KEY_POOL_SIZE = 24;
  localparam int PHASES = 12;
  localparam int PHASE_OPS = 95;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = CAPACITY + 8;

  typedef struct {
    lkvt_item_t  beat;
    int unsigned gap;
  } pending_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         start = 1'b0;
  logic         busy;
  lkvt_item_t   item = '0;
  lkvt_result_t result;
  logic         done;

  linear_key_value_table DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .result (result),
    .done   (done)
  );

  // Clock with an 8 ns period.
  always #4 clk = ~clk;

  // Shadow copy of the table contents used to predict each result.
  logic [KEY_W-1:0] shadow_key [CAPACITY];
  logic [VAL_W-1:0] shadow_val [CAPACITY];
  int               shadow_count = 0;

  pending_t     pending_beats [$];
  lkvt_result_t expected_results [$];
  logic [KEY_W-1:0] key_pool [KEY_POOL_SIZE];

  int  n_queued = 0;
  int  n_accepted = 0;
  int  error_count = 0;
  int  cycle_count = 0;
  int  n_by_command [4] = '{0, 0, 0, 0};
  int  n_hits = 0;
  int  n_drops = 0;
  int  n_full_updates = 0;
  int  peak_count = 0;
  bit  gapless = 1'b0;
  logic beat_taken = 1'b0;

  // Apply one command to the shadow table and return the result it should produce.
  function automatic lkvt_result_t apply_table_op(lkvt_item_t op);
    lkvt_result_t r;
    int pos;
    r = '0;
    pos = shadow_count;
    for (int i = 0; i < shadow_count; i++) begin
      if (shadow_key[i] == op.key) begin
        pos = i;
        break;
      end
    end
    r.found = (pos < shadow_count);
    case (op.command)
      CMD_INSERT: begin
        if (r.found) begin
          if (shadow_count == CAPACITY) n_full_updates++;
          shadow_val[pos] = op.value;
        end else if (shadow_count < CAPACITY) begin
          shadow_key[shadow_count] = op.key;
          shadow_val[shadow_count] = op.value;
          shadow_count++;
        end else begin
          r.table_full_drop = 1'b1;
          n_drops++;
        end
      end
      CMD_REMOVE: begin
        // The last entry fills the hole left by the removed one.
        if (r.found) begin
          shadow_key[pos] = shadow_key[shadow_count-1];
          shadow_val[pos] = shadow_val[shadow_count-1];
          shadow_count--;
        end
      end
      CMD_LOOKUP: begin
        if (r.found) r.read_value = shadow_val[pos];
        r.value_nonzero = (r.read_value != '0);
      end
      default: begin
      end
    endcase
    r.entries_used = USED_W'(shadow_count);
    n_by_command[op.command]++;
    if (r.found) n_hits++;
    if (shadow_count > peak_count) peak_count = shadow_count;
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Idle cycles ahead of a beat: mostly none or short, now and then long.
  function automatic int unsigned draw_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (gapless || roll < 45) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [63:0] draw_word();
    return {$urandom, $urandom};
  endfunction

  // Keys come mostly from a small pool so that hits, updates and drops are common.
  function automatic logic [KEY_W-1:0] draw_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
    return draw_word();
  endfunction

  function automatic logic [VAL_W-1:0] draw_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return '0;
    if (roll < 25) return '1;
    return draw_word();
  endfunction

  function automatic logic [CMD_W-1:0] draw_command(int ins_pct, int rem_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < ins_pct) return CMD_INSERT;
    if (roll < ins_pct + rem_pct) return CMD_REMOVE;
    if (roll < 97) return CMD_LOOKUP;
    return CMD_NOOP;
  endfunction

  task automatic queue_op(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                          logic [VAL_W-1:0] value);
    pending_t p;
    p.beat.command = cmd;
    p.beat.key = key;
    p.beat.value = value;
    p.gap = draw_gap();
    pending_beats.push_back(p);
    n_queued++;
  endtask

  // Driver: present the next beat at the falling edge once the previous one is taken.
  pending_t    staged;
  bit          have_staged = 1'b0;
  int unsigned hold = 0;

  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || beat_taken) begin
      if (!have_staged && pending_beats.size() > 0) begin
        staged = pending_beats.pop_front();
        have_staged = 1'b1;
        hold = staged.gap;
      end
      if (have_staged && hold == 0) begin
        item <= staged.beat;
        start <= 1'b1;
        have_staged = 1'b0;
      end else begin
        if (have_staged) hold--;
        start <= 1'b0;
      end
    end
  end

  // Monitor: check result beats, then record accepted command beats.
  always @(posedge clk) begin
    lkvt_result_t want;
    if (rst) begin
      beat_taken <= 1'b0;
    end else begin
      if (done === 1'b1) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %p", $time, result);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("found", want.found, result.found);
          check_field("read_value", want.read_value, result.read_value);
          check_field("value_nonzero", want.value_nonzero, result.value_nonzero);
          check_field("table_full_drop", want.table_full_drop, result.table_full_drop);
          check_field("entries_used", want.entries_used, result.entries_used);
        end
      end
      beat_taken <= start && (busy === 1'b0);
      if (start && busy === 1'b0) begin
        expected_results.push_back(apply_table_op(item));
        n_accepted++;
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Stimulus, reset and the final verdict.
  initial begin
    logic [KEY_W-1:0] k_a;
    logic [KEY_W-1:0] k_b;
    logic [KEY_W-1:0] k_c;
    int ins_pct;
    int rem_pct;

    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL_SIZE; i++) key_pool[i] = draw_word();
    k_a = draw_word();
    k_b = draw_word();
    k_c = draw_word();

    // Directed: empty table, extreme keys and values, updates, no-ops, removes.
    queue_op(CMD_LOOKUP, '0, draw_word());
    queue_op(CMD_REMOVE, '0, draw_word());
    queue_op(CMD_NOOP, '0, draw_word());
    queue_op(CMD_INSERT, '0, '0);
    queue_op(CMD_LOOKUP, '0, '1);
    queue_op(CMD_INSERT, '1, '1);
    queue_op(CMD_LOOKUP, '1, '0);
    queue_op(CMD_INSERT, '0, 64'd5);
    queue_op(CMD_NOOP, '1, '1);
    queue_op(CMD_NOOP, k_a, '1);
    queue_op(CMD_REMOVE, '1, '0);
    queue_op(CMD_LOOKUP, '1, '0);
    queue_op(CMD_INSERT, k_a, draw_word());
    queue_op(CMD_INSERT, k_b, draw_word());
    queue_op(CMD_INSERT, k_c, draw_word());
    queue_op(CMD_REMOVE, '0, '0);
    queue_op(CMD_LOOKUP, k_c, '0);
    queue_op(CMD_REMOVE, k_b, '0);
    queue_op(CMD_LOOKUP, k_a, '0);

    // Random phases that in turn fill the table past full, drain it, and mix inserts and removes.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 3)
        0: begin ins_pct = 65; rem_pct = 10; end
        1: begin ins_pct = 15; rem_pct = 55; end
        default: begin ins_pct = 35; rem_pct = 30; end
      endcase
      gapless = (ph % 4 == 3);
      for (int n = 0; n < PHASE_OPS; n++) begin
        queue_op(draw_command(ins_pct, rem_pct), draw_key(), draw_value());
      end
    end
    gapless = 1'b0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (n_accepted == n_queued);
    wait (expected_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Commands run: %0d insert, %0d remove, %0d lookup, %0d no-op; %0d hit a stored key.",
             n_by_command[CMD_INSERT], n_by_command[CMD_REMOVE], n_by_command[CMD_LOOKUP],
             n_by_command[CMD_NOOP], n_hits);
    $display("Peak occupancy %0d of %0d; %0d new keys dropped when full, %0d updates when full.",
             peak_count, CAPACITY, n_drops, n_full_updates);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/lkvt_pkg.sv
design/lkvt_ram.sv
design/lkvt_ctrl.sv
design/lkvt_dp.sv
design/linear_key_value_table.sv
tb/tb_linear_key_value_table.sv
